>>> rtl/pcmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmi_pkg
// Shared constants for the palette colour map: item kinds, result status
// codes, field widths and the default palette depth.
// ----------------------------------------------------------------------------
package pcmi_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int RGB_W   = 24;
    localparam int INDEX_W = 8;
    localparam int USED_W  = 9;
    localparam int DIST_W  = 18;
    localparam int CHAN_W  = 8;
    localparam int SQ_W    = 16;

    // item kinds
    localparam logic [1:0] KIND_MAP     = 2'd0;
    localparam logic [1:0] KIND_NEAREST = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_HIT     = 3'd0;
    localparam logic [2:0] STAT_INSERT  = 3'd1;
    localparam logic [2:0] STAT_NEAREST = 3'd2;
    localparam logic [2:0] STAT_NONE    = 3'd3;
    localparam logic [2:0] STAT_CLEARED = 3'd4;

endpackage

>>> rtl/pcmi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmi_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pcmi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/palette_color_map_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_map_insert
// Colour palette with exact-match insert and nearest-colour lookup.
// ----------------------------------------------------------------------------
// One item is handled at a time. Map and nearest items scan the palette
// entries in use, one entry per cycle through the palette RAM read port and
// a single squared-distance unit; clear items, nearest items on an empty
// palette and unused kinds skip the scan. A map item finds the first exact
// match, else appends the colour while room remains, else returns the
// nearest entry (lowest index on ties). The result sits in an output
// register, so the next item is taken while it waits. No clearing pass is
// needed after reset: only entries below the fill count are ever read.
module palette_color_map_insert #(
    parameter int PALETTE_DEPTH = pcmi_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [pcmi_pkg::CHAN_W-1:0]    i_red,
    input  logic [pcmi_pkg::CHAN_W-1:0]    i_green,
    input  logic [pcmi_pkg::CHAN_W-1:0]    i_blue,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pcmi_pkg::INDEX_W-1:0]   o_palette_index,
    output logic [2:0]                     o_status,
    output logic [pcmi_pkg::USED_W-1:0]    o_used_count,
    output logic [pcmi_pkg::DIST_W-1:0]    o_best_distance
);
    import pcmi_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [1:0]          r_kind;
    logic [RGB_W-1:0]    r_rgb;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [CW-1:0]       r_rd_idx;
    logic                r_sq_vld;
    logic [CW-1:0]       r_sq_idx;
    logic [SQ_W-1:0]     r_sq_r;
    logic [SQ_W-1:0]     r_sq_g;
    logic [SQ_W-1:0]     r_sq_b;
    logic                r_found;
    logic [CW-1:0]       r_best_idx;
    logic [DIST_W-1:0]   r_best_d;
    logic                r_out_vld;
    logic [INDEX_W-1:0]  r_out_index;
    logic [2:0]          r_out_status;
    logic [USED_W-1:0]   r_out_used;
    logic [DIST_W-1:0]   r_out_dist;

    logic [RGB_W-1:0]    w_rd_data;
    logic                w_rd_en;
    logic [CHAN_W-1:0]   w_dr;
    logic [CHAN_W-1:0]   w_dg;
    logic [CHAN_W-1:0]   w_db;
    logic [DIST_W-1:0]   w_sum;
    logic                w_take;
    logic                w_out_free;
    logic                w_fire;
    logic                w_ins;
    logic [CW-1:0]       n_index;
    logic [2:0]          n_status;
    logic [DIST_W-1:0]   n_dist;
    logic [CW-1:0]       n_count;
    logic [CW+7:0]       w_idx_ext;
    logic [CW+8:0]       w_used_ext;

    assign w_rd_en = (r_state == ST_SCAN) && (r_addr < r_count);

    pcmi_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_we      (w_fire && w_ins),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_rgb),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // absolute channel differences against the item colour
    always_comb begin
        w_dr = (w_rd_data[23:16] >= r_rgb[23:16]) ? (w_rd_data[23:16] - r_rgb[23:16])
                                                  : (r_rgb[23:16] - w_rd_data[23:16]);
        w_dg = (w_rd_data[15:8] >= r_rgb[15:8]) ? (w_rd_data[15:8] - r_rgb[15:8])
                                                : (r_rgb[15:8] - w_rd_data[15:8]);
        w_db = (w_rd_data[7:0] >= r_rgb[7:0]) ? (w_rd_data[7:0] - r_rgb[7:0])
                                              : (r_rgb[7:0] - w_rd_data[7:0]);
    end

    assign w_sum  = {2'b00, r_sq_r} + {2'b00, r_sq_g} + {2'b00, r_sq_b};
    // strict less-than keeps the lowest index on ties
    assign w_take = r_sq_vld && (!r_found || (w_sum < r_best_d));

    // result decision; the first zero-distance entry is the first exact match
    always_comb begin
        n_index  = '0;
        n_status = STAT_NONE;
        n_dist   = '0;
        w_ins    = 1'b0;
        n_count  = r_count;
        case (r_kind)
            KIND_MAP: begin
                if (r_found && (r_best_d == '0)) begin
                    n_index  = r_best_idx;
                    n_status = STAT_HIT;
                end else if (r_count < DEPTH_C) begin
                    n_index  = r_count;
                    n_status = STAT_INSERT;
                    w_ins    = 1'b1;
                    n_count  = r_count + 1'b1;
                end else begin
                    n_index  = r_best_idx;
                    n_status = STAT_NEAREST;
                    n_dist   = r_best_d;
                end
            end
            KIND_NEAREST: begin
                if (r_found) begin
                    n_index  = r_best_idx;
                    n_status = STAT_NEAREST;
                    n_dist   = r_best_d;
                end
            end
            KIND_CLEAR: begin
                n_status = STAT_CLEARED;
                n_count  = '0;
            end
            default: begin
                n_status = STAT_NONE;
            end
        endcase
    end

    assign w_idx_ext  = {8'b0, n_index};
    assign w_used_ext = {9'b0, n_count};
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_fire     = (r_state == ST_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_sq_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_en;
            r_rd_idx <= r_addr;
            r_sq_vld <= r_rd_vld;
            r_sq_idx <= r_rd_idx;
            r_sq_r   <= {8'b0, w_dr} * {8'b0, w_dr};
            r_sq_g   <= {8'b0, w_dg} * {8'b0, w_dg};
            r_sq_b   <= {8'b0, w_db} * {8'b0, w_db};
            if (w_take) begin
                r_found    <= 1'b1;
                r_best_idx <= r_sq_idx;
                r_best_d   <= w_sum;
            end

            if (r_out_vld && !i_out_stall && !w_fire) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_kind     <= i_kind;
                        r_rgb      <= {i_red, i_green, i_blue};
                        r_addr     <= '0;
                        r_found    <= 1'b0;
                        r_best_idx <= '0;
                        r_best_d   <= '0;
                        if ((i_kind == KIND_MAP) ||
                            ((i_kind == KIND_NEAREST) && (r_count != '0))) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_rd_en) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    // all reads issued and the distance pipe drained
                    if (!w_rd_en && !r_rd_vld && !r_sq_vld) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_fire) begin
                        r_out_vld    <= 1'b1;
                        r_out_index  <= w_idx_ext[7:0];
                        r_out_status <= n_status;
                        r_out_used   <= w_used_ext[8:0];
                        r_out_dist   <= n_dist;
                        r_count      <= n_count;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_palette_index = r_out_index;
    assign o_status        = r_out_status;
    assign o_used_count    = r_out_used;
    assign o_best_distance = r_out_dist;

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("palette fill count beyond depth");

    a_scan_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr <= r_count))
        else $error("scan address ran past fill count");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the decision step");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_ins) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the palette");
`endif

endmodule
